// ----- rtl/bam_pkg.sv -----
// ----------------------------------------------------------------------------
// bam_pkg
// Shared constants and types for the complex block average magnitude block.
// ----------------------------------------------------------------------------
package bam_pkg;

  // Default widths of a sample part and of the sample counter
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Fixed field widths
  localparam int CFG_W = 16;  // block_length register
  localparam int OUT_W = 16;  // magnitude and samples_in_block

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register word indexes
  localparam logic [APB_AW-3:0] REG_BLOCK_LENGTH = 1'b0;

  localparam logic [CFG_W-1:0] BLOCK_LENGTH_RST = 16'd1;

  // Block queue between accumulator and arithmetic engine
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } bam_qstat_t;

endpackage

// ----- rtl/bam_front.sv -----
// ----------------------------------------------------------------------------
// bam_front
// Sample accumulator: sums real and imaginary parts, counts samples and
// hands each closed block to the queue.
// ----------------------------------------------------------------------------
module bam_front #(
  parameter int SAMPLE_WIDTH = bam_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = bam_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic [bam_pkg::CFG_W-1:0]                    block_length,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]               sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]               sample_imag,
  input  logic                                         end_of_stream,
  input  bam_pkg::bam_qstat_t                          qstat,
  output logic                                         push,
  // {count, sum_imag, sum_real}
  output logic [2*(SAMPLE_WIDTH+COUNT_WIDTH)+COUNT_WIDTH-1:0] push_data
);
  import bam_pkg::*;

  localparam int SUMW = SAMPLE_WIDTH + COUNT_WIDTH;

  logic signed [SUMW-1:0]  sum_real;
  logic signed [SUMW-1:0]  sum_imag;
  logic [COUNT_WIDTH-1:0]  sample_count;

  logic signed [SUMW-1:0]  sum_real_next;
  logic signed [SUMW-1:0]  sum_imag_next;
  logic [COUNT_WIDTH-1:0]  sample_count_next;
  logic [COUNT_WIDTH-1:0]  blen;
  logic [COUNT_WIDTH-1:0]  limit;
  logic                    accept;
  logic                    close;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // zero length behaves as one
  assign blen  = COUNT_WIDTH'(block_length);
  assign limit = (blen == '0) ? COUNT_WIDTH'(1) : blen;

  assign sum_real_next     = sum_real + SUMW'(sample_real);
  assign sum_imag_next     = sum_imag + SUMW'(sample_imag);
  assign sample_count_next = sample_count + 1'b1;

  assign close     = end_of_stream || (sample_count_next >= limit);
  assign push      = accept && close && (sample_count_next != '0);
  assign push_data = {sample_count_next, sum_imag_next, sum_real_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_real     <= '0;
      sum_imag     <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (close) begin
        sum_real     <= '0;
        sum_imag     <= '0;
        sample_count <= '0;
      end else begin
        sum_real     <= sum_real_next;
        sum_imag     <= sum_imag_next;
        sample_count <= sample_count_next;
      end
    end
  end

endmodule

// ----- rtl/bam_queue.sv -----
// ----------------------------------------------------------------------------
// bam_queue
// Short register queue of closed blocks.
// ----------------------------------------------------------------------------
module bam_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bam_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    rd_data,
  output bam_pkg::bam_qstat_t qstat
);
  import bam_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  fill;

  assign rd_data     = entries[rd_ptr];
  assign qstat.full  = (fill == CNTW'(DEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/bam_engine.sv -----
// ----------------------------------------------------------------------------
// bam_engine
// Per-block arithmetic: two restoring dividers in step, a shared squarer,
// a digit-by-digit square root and the result register.
// ----------------------------------------------------------------------------
module bam_engine #(
  parameter int SAMPLE_WIDTH = bam_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = bam_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  bam_pkg::bam_qstat_t                          qstat,
  input  logic [2*(SAMPLE_WIDTH+COUNT_WIDTH)+COUNT_WIDTH-1:0] q_data,
  output logic                                         pop,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [bam_pkg::OUT_W-1:0]                    magnitude,
  output logic [bam_pkg::OUT_W-1:0]                    samples_in_block
);
  import bam_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COUNT_WIDTH;
  localparam int SUMW = SW + CW;
  localparam int RW   = 2 * SW;
  localparam int STW  = $clog2(SUMW);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SQ_RE, S_SQ_IM, S_ADD, S_ROOT, S_DONE
  } state_t;

  state_t             state;
  logic [STW-1:0]     step;
  logic [SUMW-1:0]    dvd_re;     // dividend, quotient shifts in from below
  logic [SUMW-1:0]    dvd_im;
  logic [CW-1:0]      rem_re;
  logic [CW-1:0]      rem_im;
  logic [CW-1:0]      divisor;
  logic [RW-1:0]      rad;
  logic [RW-1:0]      prod;
  logic [SW:0]        rrem;       // up to twice the root, one bit above it
  logic [SW-1:0]      root;

  logic signed [SUMW-1:0] q_sum_re;
  logic signed [SUMW-1:0] q_sum_im;
  logic [CW-1:0]      q_count;
  logic [SUMW-1:0]    abs_re;
  logic [SUMW-1:0]    abs_im;
  logic [CW:0]        trial_re;
  logic [CW:0]        trial_im;
  logic [CW:0]        diff_re;
  logic [CW:0]        diff_im;
  logic               ge_re;
  logic               ge_im;
  logic [SW-1:0]      mul_op;
  logic [RW-1:0]      mul;
  logic [SW+2:0]      rtrial;
  logic [SW+2:0]      rsub;
  logic [SW+2:0]      rdiff;
  logic               rge;
  logic               out_free;

  assign q_sum_re = q_data[SUMW-1:0];
  assign q_sum_im = q_data[2*SUMW-1:SUMW];
  assign q_count  = q_data[2*SUMW+CW-1:2*SUMW];

  // |trunc(s/c)| = floor(|s|/c)
  assign abs_re = q_sum_re[SUMW-1] ? SUMW'(-q_sum_re) : SUMW'(q_sum_re);
  assign abs_im = q_sum_im[SUMW-1] ? SUMW'(-q_sum_im) : SUMW'(q_sum_im);

  assign pop = (state == S_IDLE) && !qstat.empty;

  assign trial_re = {rem_re, dvd_re[SUMW-1]};
  assign trial_im = {rem_im, dvd_im[SUMW-1]};
  assign ge_re    = trial_re >= {1'b0, divisor};
  assign ge_im    = trial_im >= {1'b0, divisor};
  assign diff_re  = trial_re - {1'b0, divisor};
  assign diff_im  = trial_im - {1'b0, divisor};

  assign mul_op = (state == S_SQ_RE) ? dvd_re[SW-1:0] : dvd_im[SW-1:0];
  assign mul    = RW'(mul_op) * RW'(mul_op);

  assign rtrial = {rrem, rad[RW-1:RW-2]};
  assign rsub   = {1'b0, root, 2'b01};
  assign rge    = rtrial >= rsub;
  assign rdiff  = rtrial - rsub;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            dvd_re  <= abs_re;
            dvd_im  <= abs_im;
            rem_re  <= '0;
            rem_im  <= '0;
            divisor <= q_count;
            step    <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_re <= ge_re ? diff_re[CW-1:0] : trial_re[CW-1:0];
          rem_im <= ge_im ? diff_im[CW-1:0] : trial_im[CW-1:0];
          dvd_re <= {dvd_re[SUMW-2:0], ge_re};
          dvd_im <= {dvd_im[SUMW-2:0], ge_im};
          step   <= step + 1'b1;
          if (step == STW'(SUMW - 1)) begin
            state <= S_SQ_RE;
          end
        end
        S_SQ_RE: begin
          rad   <= mul;
          state <= S_SQ_IM;
        end
        S_SQ_IM: begin
          prod  <= mul;
          state <= S_ADD;
        end
        S_ADD: begin
          rad   <= rad + prod;
          rrem  <= '0;
          root  <= '0;
          step  <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          rrem <= rge ? rdiff[SW:0] : rtrial[SW:0];
          root <= {root[SW-2:0], rge};
          rad  <= {rad[RW-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == STW'(SW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            magnitude        <= OUT_W'(root);
            samples_in_block <= OUT_W'(divisor);
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/complex_block_average_magnitude_top.sv -----
// ----------------------------------------------------------------------------
// complex_block_average_magnitude_top
// Block mean of a complex Q1.15 sample stream, reported as its modulus.
// ----------------------------------------------------------------------------
// Samples arrive on the slave stream, real part in the low half of s_tdata,
// imaginary part above it, s_tlast marking the final sample of a stream.
// Every block_length samples (or at s_tlast, over however many samples came
// in) the block emits one item: floor(sqrt(mr^2 + mi^2)) where mr and mi are
// the block sums divided by the sample count, truncated toward zero, plus
// that count. A block_length of zero acts as one. The accumulator takes one
// item per clock while the queue is not full; each closed block goes into
// a two-entry queue and is then worked on by the arithmetic engine, which
// pops it, runs the two restoring dividers side by side bit by bit, squares
// both means in turn on the shared squarer, adds the squares, takes the
// square root bit by bit and hands the result over. Blocks no shorter than
// an engine pass therefore stream at one item per clock while the master
// side keeps up; shorter blocks hold s_tready low once the queue is full,
// and the sustained rate is then one block per engine pass.
// Results wait in an output register, so the engine and the accumulator
// keep going while the master side is stalled, until the queue fills.
// block_length sits at byte address 0 of the APB port and resets to 1.
// ----------------------------------------------------------------------------
module complex_block_average_magnitude_top #(
  parameter int SAMPLE_WIDTH = bam_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = bam_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bam_pkg::APB_AW-1:0]         paddr,
  input  logic [bam_pkg::APB_DW-1:0]         pwdata,
  output logic [bam_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  // sample items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample_real, sample_imag, zero pad to whole bytes
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic                               s_tlast,  // end_of_stream
  // result items
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // magnitude, samples_in_block
  output logic [2*bam_pkg::OUT_W-1:0]        m_tdata
);
  import bam_pkg::*;

  localparam int SUMW = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int QW   = 2 * SUMW + COUNT_WIDTH;

  logic [CFG_W-1:0]              block_length;
  logic                          cfg_write;
  logic signed [SAMPLE_WIDTH-1:0] sample_real;
  logic signed [SAMPLE_WIDTH-1:0] sample_imag;
  logic                          q_push;
  logic [QW-1:0]                 q_wr_data;
  logic                          q_pop;
  logic [QW-1:0]                 q_rd_data;
  bam_qstat_t                    qstat;
  logic [OUT_W-1:0]              magnitude;
  logic [OUT_W-1:0]              samples_in_block;

  // --- configuration register -----------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LENGTH_RST;
    end else if (cfg_write && (paddr[APB_AW-1:2] == REG_BLOCK_LENGTH)) begin
      block_length <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1:2] == REG_BLOCK_LENGTH) ?
                  APB_DW'(block_length) : '0;

  // --- stream unpacking -----------------------------------------------------
  assign sample_real = s_tdata[SAMPLE_WIDTH-1:0];
  assign sample_imag = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  // --- accumulator ----------------------------------------------------------
  bam_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .block_length  (block_length),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .sample_real   (sample_real),
    .sample_imag   (sample_imag),
    .end_of_stream (s_tlast),
    .qstat         (qstat),
    .push          (q_push),
    .push_data     (q_wr_data)
  );

  // --- closed-block queue ---------------------------------------------------
  bam_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .qstat   (qstat)
  );

  // --- divide, square, root -------------------------------------------------
  bam_engine #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .qstat            (qstat),
    .q_data           (q_rd_data),
    .pop              (q_pop),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .magnitude        (magnitude),
    .samples_in_block (samples_in_block)
  );

  assign m_tdata = {samples_in_block, magnitude};

  // --- checks ---------------------------------------------------------------
`ifndef SYNTHESIS
  // the accumulator must never hand over a block while the queue is full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("block pushed into a full queue");

  // the engine only takes a block that is there
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("block popped from an empty queue");

  // a closed block always holds at least one sample
  a_block_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_wr_data[QW-1:2*SUMW] != '0))
    else $error("empty block handed to the engine");

  // a pushed block with no pop in that cycle shows up in the queue status in the next cycle
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !qstat.empty)
    else $error("queue empty after a push");
`endif

endmodule

// ----- tb/complex_block_average_magnitude_top_tb.sv -----
// ----------------------------------------------------------------------------
// complex_block_average_magnitude_top_tb
// Self-checking bench for the block mean complex magnitude stream.
// ----------------------------------------------------------------------------
// Samples go in on the slave stream and block_length is set over APB.
// A directed table comes first: extremes, length zero, partial final
// block, truncation toward zero and a length lowered mid block. Random
// phases under several block lengths follow, 0, 1 and 65535 among them.
// A local model of the accumulator works out the magnitude and count of
// each closed block that has no typed-in result, and every result item is
// checked in order. Both sides idle at random but for one phase. One phase
// holds the master side off for a long stretch so that the queue fills.
// Another pauses the sender until every block has come out.
// ----------------------------------------------------------------------------
module complex_block_average_magnitude_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bam_pkg::*;

  localparam int SETTLE      = 120;     // covers an engine pass plus queue
  localparam int HOLD_CYCLES = 400;     // long master-side stall
  localparam int LIMIT       = 600000;  // cycles before the run is abandoned
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 160;
  localparam int DIR_ROWS    = 24;

  typedef struct packed {
    logic [OUT_W-1:0] mag;
    logic [OUT_W-1:0] cnt;
  } block_res_t;

  // one row of the directed table: optional register write, the sample,
  // and a typed-in result where it is obvious
  typedef struct packed {
    logic             cfg_wr;
    logic [CFG_W-1:0] cfg_val;
    logic [15:0]      re;
    logic [15:0]      im;
    logic             eos;
    logic             typed;
    logic [OUT_W-1:0] t_mag;
    logic [OUT_W-1:0] t_cnt;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;   // sample_real, sample_imag
  logic              s_tlast = 1'b0; // end_of_stream
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;        // magnitude, samples_in_block

  complex_block_average_magnitude_top uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: sums, count and register copy
  logic signed [31:0] acc_real = '0;
  logic signed [31:0] acc_imag = '0;
  logic [15:0]        acc_count = '0;
  logic [CFG_W-1:0]   blen_reg = BLOCK_LENGTH_RST;

  block_res_t expected_blocks [$];
  int         mismatches = 0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;
  bit         hold_req = 1'b0;

  // directed table; rows with typed = 0 are checked against the model
  stim_row_t dir_tab [DIR_ROWS] = '{
    // length 1 out of reset: each sample is its own block
    '{1'b0, 16'd0, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'd0,     16'd1},
    '{1'b0, 16'd0, 16'h7FFF, 16'h0000, 1'b0, 1'b1, 16'd32767, 16'd1},
    '{1'b0, 16'd0, 16'h8000, 16'h0000, 1'b0, 1'b1, 16'd32768, 16'd1},
    '{1'b0, 16'd0, 16'h0000, 16'h8000, 1'b1, 1'b1, 16'd32768, 16'd1},
    '{1'b0, 16'd0, 16'h8000, 16'h8000, 1'b0, 1'b1, 16'd46340, 16'd1},
    '{1'b0, 16'd0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'd46339, 16'd1},
    '{1'b0, 16'd0, 16'h0003, 16'h0004, 1'b0, 1'b1, 16'd5,     16'd1},
    '{1'b0, 16'd0, 16'hFFFD, 16'hFFFC, 1'b0, 1'b1, 16'd5,     16'd1},
    // length zero acts as one
    '{1'b1, 16'd0, 16'h0005, 16'h000C, 1'b0, 1'b1, 16'd13,    16'd1},
    // full block of four
    '{1'b1, 16'd4, 16'h0064, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h0064, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h0064, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h0065, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    // partial final block of two
    '{1'b0, 16'd0, 16'h0007, 16'hFFF9, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h0001, 16'h0001, 1'b1, 1'b0, 16'd0,     16'd0},
    // -3 / 2 truncates toward zero
    '{1'b0, 16'd0, 16'hFFFD, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'd0,     16'd0},
    // two samples in, then length dropped to two: third closes the block
    '{1'b0, 16'd0, 16'h000A, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h000A, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b1, 16'd2, 16'h000A, 16'h0000, 1'b0, 1'b0, 16'd0,     16'd0},
    // longest length, flushed by end of stream
    '{1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'd0,  16'd0},
    '{1'b0, 16'd0, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'd0,     16'd0},
    '{1'b0, 16'd0, 16'h8000, 16'h8000, 1'b1, 1'b0, 16'd0,     16'd0}
  };

  // floor of the square root, one result bit at a time from the top
  function automatic logic [OUT_W-1:0] floor_root(input logic [63:0] x);
    logic [OUT_W-1:0] root;
    logic [OUT_W-1:0] trial;
    root = '0;
    for (int b = OUT_W - 1; b >= 0; b--) begin
      trial = root | (OUT_W'(1) << b);
      if ({48'd0, trial} * {48'd0, trial} <= x) root = trial;
    end
    return root;
  endfunction

  // add one sample to the running block; returns 1 when the block closes
  function automatic bit accumulate_sample(input logic signed [15:0] re,
                                           input logic signed [15:0] im,
                                           input logic eos,
                                           output block_res_t res);
    logic [15:0]        limit;
    logic signed [31:0] mr, mi;
    logic [31:0]        ar, ai;
    logic [63:0]        pw;
    limit = (blen_reg == '0) ? 16'd1 : blen_reg;
    acc_real  = acc_real + re;
    acc_imag  = acc_imag + im;
    acc_count = acc_count + 16'd1;
    res = '0;
    if (!(eos || acc_count >= limit)) return 1'b0;
    mr = acc_real / $signed({16'd0, acc_count});
    mi = acc_imag / $signed({16'd0, acc_count});
    ar = (mr < 0) ? -mr : mr;
    ai = (mi < 0) ? -mi : mi;
    pw = 64'(ar) * 64'(ar) + 64'(ai) * 64'(ai);
    res.mag = floor_root(pw);
    res.cnt = acc_count;
    acc_real  = '0;
    acc_imag  = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  // one sample part: extremes and small values weighted in
  function automatic logic [15:0] pick_part();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(32)) - 16);
      3: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // APB write: setup then access; the model copy follows on completion
  task automatic cfg_write(input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCK_LENGTH, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    blen_reg = val;
  endtask

  // offer one sample (after a random gap) and hold it until accepted
  task automatic send_item(input logic [15:0] re, input logic [15:0] im,
                           input logic eos, input logic typed,
                           input logic [OUT_W-1:0] t_mag,
                           input logic [OUT_W-1:0] t_cnt);
    block_res_t res;
    bit         closes;
    while (tx_idle_en && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {im, re};
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    closes = accumulate_sample(re, im, eos, res);
    if (typed) begin
      closes  = 1'b1;
      res.mag = t_mag;
      res.cnt = t_cnt;
    end
    if (closes) expected_blocks.push_back(res);
  endtask

  // stop offering, wait for every block to come out, then let things settle
  task automatic drain_results(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_blocks.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // master side: check each accepted item, then pick next tready
  initial begin
    block_res_t want;
    int         hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (expected_blocks.size() == 0) begin
          $error("result item with none expected: magnitude %0d samples_in_block %0d",
                 m_tdata[15:0], m_tdata[31:16]);
          mismatches++;
        end else begin
          want = expected_blocks.pop_front();
          if (m_tdata[15:0] !== want.mag) begin
            $error("magnitude: expected %0d, got %0d", want.mag, m_tdata[15:0]);
            mismatches++;
          end
          if (m_tdata[31:16] !== want.cnt) begin
            $error("samples_in_block: expected %0d, got %0d", want.cnt, m_tdata[31:16]);
            mismatches++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(rx_idle_en && $urandom_range(99) < 13);
      end
    end
  end

  // watchdog
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t        row;
    logic [CFG_W-1:0] blen;
    int               eos_pct;
    // hold synchronous reset, then release it
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      if (row.cfg_wr) begin
        drain_results(SETTLE);
        cfg_write(row.cfg_val);
      end
      send_item(row.re, row.im, row.eos, row.typed, row.t_mag, row.t_cnt);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       blen = 16'd1;
        1:       blen = 16'd0;
        2:       blen = 16'($urandom_range(8, 2));
        3:       blen = 16'($urandom_range(64, 9));
        4:       blen = 16'hFFFF;
        5:       blen = 16'd1;
        6:       blen = 16'($urandom_range(200, 60));
        7:       blen = 16'($urandom_range(65535, 1));
        8:       blen = 16'd2;
        default: blen = 16'($urandom_range(16, 1));
      endcase
      // register changes only with the block idle; a partial block may be
      // left over and is then closed under the new length
      drain_results(SETTLE);
      cfg_write(blen);
      // one long stretch with no idling on either side
      tx_idle_en = (ph != 2);
      rx_idle_en = (ph != 2);
      eos_pct = (blen > 16'd1000) ? 5 : 3;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // master held off while one-sample blocks keep coming: queue fills
        if (ph == 5 && n == 10) hold_req = 1'b1;
        // sender pause until everything has come out
        if (ph == 8 && n == 80) drain_results(0);
        send_item(pick_part(), pick_part(), $urandom_range(99) < eos_pct,
                  1'b0, '0, '0);
      end
    end

    drain_results(SETTLE);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- complex_block_average_magnitude_top.f -----
rtl/bam_pkg.sv
rtl/bam_front.sv
rtl/bam_queue.sv
rtl/bam_engine.sv
rtl/complex_block_average_magnitude_top.sv
tb/complex_block_average_magnitude_top_tb.sv
